>>> design/rhfd_pkg.sv
// shared types and constants for the rtp h264 fu-a depacketizer
`default_nettype none

package rhfd_pkg;

   localparam logic [4:0] NAL_TYPE_SINGLE_LIMIT = 5'd24;
   localparam logic [4:0] NAL_TYPE_FU_A         = 5'd28;

   localparam logic [2:0] START_CODE_LEN_SHORT = 3'd3;
   localparam logic [2:0] START_CODE_LEN_LONG  = 3'd4;
   localparam logic [2:0] START_CODE_LEN_NONE  = 3'd0;

   localparam logic [7:0] START_CODE_ZERO = 8'h00;
   localparam logic [7:0] START_CODE_ONE  = 8'h01;

   typedef struct packed {
      logic [7:0] payload_byte;
      logic       packet_first;
      logic       packet_last;
   } req_type;

   typedef struct packed {
      logic [7:0] stream_byte;
      logic       byte_valid;
      logic       nal_begin;
      logic       nal_finish;
      logic       run_last;
   } rsp_type;

   // one decoded item: optional start code followed by one closing result
   typedef struct packed {
      logic       present;
      logic [2:0] sc_len;
      logic [7:0] tail_byte;
      logic       tail_valid;
      logic       tail_finish;
   } desc_type;

endpackage

`default_nettype wire

>>> design/rhfd_decode.sv
// packet parser: tracks packet phase and fragment state, builds one descriptor per item
`default_nettype none

module rhfd_decode
   import rhfd_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire req_type  item,
   input  wire logic     advance,
   input  wire logic     long_start_code,
   output desc_type      desc
);

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_SINGLE,
      PH_FU_HDR,
      PH_FU_DATA,
      PH_DROP
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [2:0] ind_ff, ind_in;
   logic       open_ff, open_in;
   logic       end_ff, end_in;

   logic [7:0] b;
   logic       last;
   logic [2:0] sc_len;
   logic       fin;

   assign b      = item.payload_byte;
   assign last   = item.packet_last;
   assign sc_len = long_start_code ? START_CODE_LEN_LONG : START_CODE_LEN_SHORT;

   always_comb begin
      phase_in         = phase_ff;
      ind_in           = ind_ff;
      open_in          = open_ff;
      end_in           = end_ff;
      fin              = 1'b0;
      desc.present     = 1'b0;
      desc.sc_len      = START_CODE_LEN_NONE;
      desc.tail_byte   = b;
      desc.tail_valid  = 1'b1;
      desc.tail_finish = 1'b0;
      if (item.packet_first) begin
         if (b[4:0] < NAL_TYPE_SINGLE_LIMIT) begin
            open_in          = 1'b0;
            desc.present     = 1'b1;
            desc.sc_len      = sc_len;
            desc.tail_finish = last;
            phase_in         = last ? PH_IDLE : PH_SINGLE;
         end else if (b[4:0] == NAL_TYPE_FU_A) begin
            ind_in   = b[7:5];
            phase_in = last ? PH_IDLE : PH_FU_HDR;
         end else begin
            phase_in = last ? PH_IDLE : PH_DROP;
         end
      end else begin
         unique case (phase_ff)
            PH_SINGLE: begin
               desc.present     = 1'b1;
               desc.tail_finish = last;
               if (last) phase_in = PH_IDLE;
            end
            PH_FU_HDR: begin
               end_in = b[6];
               if (b[7]) begin
                  fin              = last && b[6];
                  desc.present     = 1'b1;
                  desc.sc_len      = sc_len;
                  desc.tail_byte   = {ind_ff, b[4:0]};
                  desc.tail_finish = fin;
                  open_in          = !fin;
                  phase_in         = last ? PH_IDLE : PH_FU_DATA;
               end else if (!open_ff) begin
                  phase_in = last ? PH_IDLE : PH_DROP;
               end else if (last) begin
                  if (b[6]) begin
                     // end bit on a header-only packet: marker-only result
                     desc.present     = 1'b1;
                     desc.tail_byte   = START_CODE_ZERO;
                     desc.tail_valid  = 1'b0;
                     desc.tail_finish = 1'b1;
                     open_in          = 1'b0;
                  end
                  phase_in = PH_IDLE;
               end else begin
                  phase_in = PH_FU_DATA;
               end
            end
            PH_FU_DATA: begin
               if (open_ff) begin
                  fin              = last && end_ff;
                  desc.present     = 1'b1;
                  desc.tail_finish = fin;
                  if (fin) open_in = 1'b0;
               end
               if (last) phase_in = PH_IDLE;
            end
            PH_DROP: begin
               if (last) phase_in = PH_IDLE;
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         ind_ff   <= 3'd0;
         open_ff  <= 1'b0;
         end_ff   <= 1'b0;
      end else if (advance) begin
         phase_ff <= phase_in;
         ind_ff   <= ind_in;
         open_ff  <= open_in;
         end_ff   <= end_in;
      end
   end

endmodule

`default_nettype wire

>>> design/rhfd_emit.sv
// result sequencer: plays out one descriptor as start code bytes and a closing result
`default_nettype none

module rhfd_emit
   import rhfd_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire desc_type desc_in,
   input  wire logic     desc_offer,
   output logic          desc_free,
   output logic          rsp_valid,
   input  wire logic     rsp_ready,
   output rsp_type       rsp_data
);

   desc_type   desc_ff;
   logic       desc_valid_ff;
   logic [2:0] idx_ff;
   rsp_type    rsp_data_ff;
   logic       rsp_valid_ff;

   logic       out_free;
   logic       emit;
   logic       at_tail;
   rsp_type    result;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign emit      = desc_valid_ff && out_free;
   assign at_tail   = (idx_ff == desc_ff.sc_len);
   assign desc_free = !desc_valid_ff || (emit && at_tail);

   always_comb begin
      if (at_tail) begin
         result.stream_byte = desc_ff.tail_byte;
         result.byte_valid  = desc_ff.tail_valid;
         result.nal_begin   = 1'b0;
         result.nal_finish  = desc_ff.tail_finish;
         result.run_last    = 1'b1;
      end else begin
         result.stream_byte = (idx_ff == desc_ff.sc_len - 3'd1) ? START_CODE_ONE
                                                                : START_CODE_ZERO;
         result.byte_valid  = 1'b1;
         result.nal_begin   = (idx_ff == 3'd0);
         result.nal_finish  = 1'b0;
         result.run_last    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         desc_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         idx_ff        <= 3'd0;
      end else begin
         if (out_free) rsp_valid_ff <= emit;
         if (desc_free) begin
            desc_valid_ff <= desc_offer && desc_in.present;
            idx_ff        <= 3'd0;
         end else if (emit) begin
            idx_ff <= idx_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit) rsp_data_ff <= result;
      if (desc_free) desc_ff <= desc_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_finish_ends_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.nal_finish |-> rsp_data_ff.run_last)
      else $error("nal_finish on a result that is not last of its run");

   a_begin_is_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.nal_begin |->
         rsp_data_ff.byte_valid && rsp_data_ff.stream_byte == START_CODE_ZERO
         && !rsp_data_ff.run_last)
      else $error("nal_begin not on a leading start code zero");

   a_marker_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_data_ff.byte_valid |->
         rsp_data_ff.nal_finish && rsp_data_ff.run_last)
      else $error("marker-only result without nal_finish");

   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      desc_valid_ff |-> idx_ff <= desc_ff.sc_len)
      else $error("sequencer index ran past the descriptor");

endmodule

`default_nettype wire

>>> design/rtp_h264_fua_depacketizer_core.sv
// top level of the rtp h264 single nal / fu-a to annex b depacketizer
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/ready    | req_type: payload_byte, packet_first, packet_last
//   rsp     | out       | rsp_valid/ready    | rsp_type: stream_byte, byte_valid, nal_begin,
//           |           |                    |           nal_finish, run_last
//   csr     | in        | csr_write_enable   | csr_write_data = long_start_code
//
// one item per cycle while each item gives at most one result and rsp_ready is not holding the output
// an item that opens a nal unit gives 4 or 5 results and holds the result sequencer
// until its last result is taken; input backs up behind it
// an item passes the input, descriptor and output registers on its way to its first result
// synchronous reset clears all control state and long_start_code
`default_nettype none

module rtp_h264_fua_depacketizer_core
   import rhfd_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data,
   input  wire logic    csr_write_enable,
   input  wire logic    csr_write_data
);

   req_type  item_ff;
   logic     item_valid_ff;
   logic     long_start_code_ff;

   logic     advance;
   logic     desc_free;
   desc_type desc;

   assign advance   = item_valid_ff && desc_free;
   assign req_ready = !item_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff      <= 1'b0;
         long_start_code_ff <= 1'b0;
      end else begin
         if (req_ready) item_valid_ff <= req_valid;
         if (csr_write_enable) long_start_code_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) item_ff <= req_data;
   end

   rhfd_decode u_decode (
      .clock           (clock),
      .reset           (reset),
      .item            (item_ff),
      .advance         (advance),
      .long_start_code (long_start_code_ff),
      .desc            (desc)
   );

   rhfd_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .desc_in    (desc),
      .desc_offer (item_valid_ff),
      .desc_free  (desc_free),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

`default_nettype wire
